FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tms assertion failed");

// Next-cycle implication, disabled during reset.
`define TMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tms assertion failed");

`endif

FILE: design/tms_pkg.sv
// Types, constants and helper functions for the triangle subdivider.
// Depends on nothing; used by every module of the block.
package tms_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_y;
    logic signed [15:0] tan_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [15:0] out_norm_x;
    logic signed [15:0] out_norm_y;
    logic signed [15:0] out_norm_z;
    logic signed [15:0] out_tan_x;
    logic signed [15:0] out_tan_y;
    logic signed [15:0] out_tan_z;
    logic signed [15:0] out_tex_u;
    logic signed [15:0] out_tex_v;
    logic               last_of_triangle;
  } out_vertex_t;

  typedef struct packed {
    vertex_t v0;
    vertex_t v1;
    vertex_t v2;
  } tri_t;

  localparam int QueueDepth = 2;

  // Renormalisation widths.
  localparam int SumW    = 17;  // sum of two Q2.14 components
  localparam int MagW    = 17;  // magnitude of such a sum
  localparam int SqW     = 33;  // one squared magnitude
  localparam int SsW     = 34;  // sum of three squares
  localparam int RemW    = 35;  // divider remainder after its shift
  localparam int QuoW    = 31;  // quotient, at most 2**30
  localparam int RootW   = 31;  // root register inside the square-root loop
  localparam int DivSteps  = 31;
  localparam int SqrtSteps = 16;

  function automatic logic signed [31:0] half_floor32(logic signed [31:0] a,
                                                     logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    return s[32:1];
  endfunction

  function automatic logic signed [15:0] half_floor16(logic signed [15:0] a,
                                                     logic signed [15:0] b);
    logic signed [16:0] s;
    s = 17'(a) + 17'(b);
    return s[16:1];
  endfunction

  function automatic out_vertex_t corner_out(vertex_t v);
    out_vertex_t o;
    o.out_pos_x  = v.pos_x;
    o.out_pos_y  = v.pos_y;
    o.out_pos_z  = v.pos_z;
    o.out_norm_x = v.norm_x;
    o.out_norm_y = v.norm_y;
    o.out_norm_z = v.norm_z;
    o.out_tan_x  = v.tan_x;
    o.out_tan_y  = v.tan_y;
    o.out_tan_z  = v.tan_z;
    o.out_tex_u  = v.tex_u;
    o.out_tex_v  = v.tex_v;
    o.last_of_triangle = 1'b0;
    return o;
  endfunction

endpackage

FILE: design/triangle_midpoint_subdivider.sv
// Top level of the triangle midpoint subdivider: front end, triangle queue
// and back end. Depends on tms_pkg, tms_front, tms_queue, tms_back, assert_macros.svh.
//
//   channel | direction | handshake           | word
//   in      | input     | in_valid/in_ready   | tms_pkg::vertex_t, one corner
//   out     | output    | out_valid/out_ready | tms_pkg::out_vertex_t, one vertex
//
// The first two corners of a triangle are taken one per cycle; the third
// needs a free queue slot. The back end emits each triangle as three corner
// words, then three midpoints, each computed by the bit-serial divider
// (31 steps) and square root (16 steps). Reset is synchronous and clears
// all control state. A stalled out_ready holds the output word and fills
// the queue before in_ready drops.
module triangle_midpoint_subdivider #(
  parameter int QDEPTH = tms_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tms_pkg::vertex_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tms_pkg::out_vertex_t out_data
);
  import tms_pkg::*;
  `include "assert_macros.svh"

  logic q_push, q_full, q_pop, q_head_valid;
  tri_t q_in, q_head;

  tms_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  tms_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .head_valid(q_head_valid), .head(q_head)
  );

  tms_back u_back (
    .clk(clk), .rst_n(rst_n), .head_valid(q_head_valid), .head(q_head),
    .pop(q_pop), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  `TMS_ASSERT_NOW(a_no_overflow, q_push, !q_full)
  `TMS_ASSERT_NOW(a_no_underflow, q_pop, q_head_valid)
  `TMS_ASSERT_NEXT(a_pop_last, q_pop, out_valid && out_data.last_of_triangle)

endmodule

FILE: design/tms_front.sv
// Front end: holds the first two corners and pushes whole triangles.
// Depends on tms_pkg.
module tms_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tms_pkg::vertex_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output tms_pkg::tri_t    q_data
);
  import tms_pkg::*;

  logic [1:0] count_r, count_nxt;
  vertex_t    held0_r, held1_r;
  logic       accept;
  logic       third;

  assign third    = count_r[1];
  assign in_ready = !third || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && third;
  assign q_data   = '{v0: held0_r, v1: held1_r, v2: in_data};

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = third ? 2'd0 : count_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && count_r == 2'd0) begin
      held0_r <= in_data;
    end
    if (accept && count_r == 2'd1) begin
      held1_r <= in_data;
    end
  end

endmodule

FILE: design/tms_queue.sv
// Short triangle queue between the front and back ends.
// Depends on tms_pkg.
module tms_queue #(
  parameter int DEPTH = tms_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tms_pkg::tri_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output tms_pkg::tri_t head
);
  import tms_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tri_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

FILE: design/tms_renorm.sv
// Scales a three-component sum to unit length in Q2.14, one bit per cycle
// in a restoring divider and then a bit-serial square root, three lanes.
// Depends on tms_pkg.
module tms_renorm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [2:0][tms_pkg::SumW-1:0]     s_in,
  output logic                              done,
  output logic [2:0][15:0]                  res
);
  import tms_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]                 state_r, state_nxt;
  logic [4:0]                 cnt_r, cnt_nxt;
  logic                       done_r, done_nxt;
  logic [2:0]                 neg_r;
  logic [2:0][MagW-1:0]       mag_r;
  logic [2:0][SqW-1:0]        sq_r;
  logic [SsW-1:0]             ss_r;
  logic [2:0][RemW-1:0]       rem_r, rem_nxt;
  logic [2:0][QuoW-1:0]       q_r, q_nxt;
  logic [2:0][QuoW-1:0]       n_r, n_nxt;
  logic [2:0][RootW-1:0]      root_r, root_nxt;
  logic [QuoW-1:0]            bit_r;
  logic [2:0][15:0]           res_r, res_nxt;

  assign done = done_r;
  assign res  = res_r;

  always_comb begin
    logic [RemW-1:0]  diff;
    logic             ge;
    logic [RootW:0]   trial;
    logic [16:0]      half;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    n_nxt     = n_r;
    root_nxt  = root_r;
    res_nxt   = res_r;
    for (int i = 0; i < 3; i++) begin
      diff = rem_r[i] - RemW'(ss_r);
      ge   = (rem_r[i] >= RemW'(ss_r));
      trial = (RootW+1)'(root_r[i]) + (RootW+1)'(bit_r);
      half  = 17'((18'(root_r[i][16:0]) + 18'd1) >> 1);
      case (state_r)
        ST_SUM: begin
          rem_nxt[i] = RemW'(sq_r[i]);
          q_nxt[i]   = '0;
        end
        ST_DIV: begin
          rem_nxt[i] = RemW'({(ge ? diff : rem_r[i]), 1'b0});
          q_nxt[i]   = {q_r[i][QuoW-2:0], ge};
        end
        ST_SQRT: begin
          if (cnt_r == 5'd0) begin
            n_nxt[i]    = q_r[i];
            root_nxt[i] = '0;
          end else if ((RootW+1)'(n_r[i]) >= trial) begin
            n_nxt[i]    = QuoW'((RootW+1)'(n_r[i]) - trial);
            root_nxt[i] = RootW'((root_r[i] >> 1) + RootW'(bit_r));
          end else begin
            root_nxt[i] = root_r[i] >> 1;
          end
        end
        ST_FIN: begin
          if (ss_r == '0) begin
            res_nxt[i] = '0;
          end else begin
            res_nxt[i] = neg_r[i] ? -half[15:0] : half[15:0];
          end
        end
        default: begin
        end
      endcase
    end
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SQ;
          done_nxt  = 1'b0;
        end
      end
      ST_SQ:  state_nxt = ST_SUM;
      ST_SUM: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        if (cnt_r == 5'(DivSteps - 1)) begin
          state_nxt = ST_SQRT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_SQRT: begin
        // The first cycle loads the radicand; the next ones each take one root bit.
        if (cnt_r == 5'(SqrtSteps)) begin
          state_nxt = ST_FIN;
        end
        cnt_nxt = cnt_r + 5'd1;
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
        done_nxt  = 1'b1;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= s_in[i][SumW-1];
        mag_r[i] <= s_in[i][SumW-1] ? MagW'(-s_in[i]) : MagW'(s_in[i]);
      end
    end
    if (state_r == ST_SQ) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= SqW'(mag_r[i] * mag_r[i]);
      end
    end
    if (state_r == ST_SUM) begin
      ss_r <= SsW'(sq_r[0]) + SsW'(sq_r[1]) + SsW'(sq_r[2]);
    end
    if (state_r == ST_SQRT) begin
      bit_r <= (cnt_r == 5'd0) ? QuoW'(1) << (QuoW - 1) : bit_r >> 2;
    end
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    n_r    <= n_nxt;
    root_r <= root_nxt;
    res_r  <= res_nxt;
  end

endmodule

FILE: design/tms_back.sv
// Back end: emits three corners and three midpoints of the head triangle
// through an output register, using two renormalisation units.
// Depends on tms_pkg and tms_renorm.
module tms_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  tms_pkg::tri_t        head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tms_pkg::out_vertex_t out_data
);
  import tms_pkg::*;

  localparam logic [1:0] ST_CORNER = 2'd0;
  localparam logic [1:0] ST_START  = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_PUT    = 2'd3;

  logic [1:0]   state_r, state_nxt;
  logic [1:0]   idx_r, idx_nxt;
  logic         ovalid_r, ovalid_nxt;
  out_vertex_t  odata_r, odata_nxt;
  logic         slot_free;
  vertex_t      va, vb, vc;
  logic         start;
  logic         nrm_done, tan_done;
  logic [2:0][SumW-1:0] nrm_sum, tan_sum;
  logic [2:0][15:0]     nrm_res, tan_res;
  out_vertex_t  mid;

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;
  assign slot_free = !ovalid_r || out_ready;
  assign start     = (state_r == ST_START);

  // Midpoint 0 joins v0 and v1, midpoint 1 joins v1 and v2, midpoint 2 joins v0 and v2.
  assign va = (idx_r == 2'd1) ? head.v1 : head.v0;
  assign vb = (idx_r == 2'd0) ? head.v1 : head.v2;

  assign nrm_sum[0] = SumW'(va.norm_x) + SumW'(vb.norm_x);
  assign nrm_sum[1] = SumW'(va.norm_y) + SumW'(vb.norm_y);
  assign nrm_sum[2] = SumW'(va.norm_z) + SumW'(vb.norm_z);
  assign tan_sum[0] = SumW'(va.tan_x) + SumW'(vb.tan_x);
  assign tan_sum[1] = SumW'(va.tan_y) + SumW'(vb.tan_y);
  assign tan_sum[2] = SumW'(va.tan_z) + SumW'(vb.tan_z);

  tms_renorm u_nrm (
    .clk(clk), .rst_n(rst_n), .start(start), .s_in(nrm_sum),
    .done(nrm_done), .res(nrm_res)
  );

  tms_renorm u_tan (
    .clk(clk), .rst_n(rst_n), .start(start), .s_in(tan_sum),
    .done(tan_done), .res(tan_res)
  );

  always_comb begin
    mid.out_pos_x  = half_floor32(va.pos_x, vb.pos_x);
    mid.out_pos_y  = half_floor32(va.pos_y, vb.pos_y);
    mid.out_pos_z  = half_floor32(va.pos_z, vb.pos_z);
    mid.out_norm_x = nrm_res[0];
    mid.out_norm_y = nrm_res[1];
    mid.out_norm_z = nrm_res[2];
    mid.out_tan_x  = tan_res[0];
    mid.out_tan_y  = tan_res[1];
    mid.out_tan_z  = tan_res[2];
    mid.out_tex_u  = half_floor16(va.tex_u, vb.tex_u);
    mid.out_tex_v  = half_floor16(va.tex_v, vb.tex_v);
    mid.last_of_triangle = (idx_r == 2'd2);
  end

  always_comb begin
    vc = head.v0;
    case (idx_r)
      2'd1:    vc = head.v1;
      2'd2:    vc = head.v2;
      default: vc = head.v0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r && !out_ready;
    odata_nxt  = odata_r;
    pop        = 1'b0;
    case (state_r)
      ST_CORNER: begin
        if (head_valid && slot_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = corner_out(vc);
          if (idx_r == 2'd2) begin
            idx_nxt   = 2'd0;
            state_nxt = ST_START;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (nrm_done && tan_done) begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = mid;
          if (idx_r == 2'd2) begin
            idx_nxt   = 2'd0;
            pop       = 1'b1;
            state_nxt = ST_CORNER;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = ST_START;
          end
        end
      end
      default: state_nxt = ST_CORNER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CORNER;
      idx_r    <= 2'd0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
  end

endmodule
